/* design/mat_pkg.sv */
// ----------------------------------------------------------------------------
// Multi-slot alarm timer package
// Shared types, command codes and event codes of the alarm timer.
// ----------------------------------------------------------------------------
package mat_pkg;

  localparam int SLOTS_DEF = 4;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_END   = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [2:0] EV_STARTED   = 3'd0;
  localparam logic [2:0] EV_FULL      = 3'd1;
  localparam logic [2:0] EV_SCHEDULED = 3'd2;
  localparam logic [2:0] EV_NOT_FOUND = 3'd3;
  localparam logic [2:0] EV_RANG      = 3'd4;
  localparam logic [2:0] EV_ENDED     = 3'd5;

  typedef struct packed {
    logic        busy;
    logic        cancel;
    logic [15:0] ident;
    logic [15:0] remaining;
    logic [15:0] length;
  } slot_t;

  typedef struct packed {
    logic [2:0]  ev;
    logic [15:0] id;
    logic [15:0] len;
  } res_t;

endpackage

/* design/multi_slot_alarm_timer.sv */
// ----------------------------------------------------------------------------
// Multi-slot alarm timer
// A table of SLOTS alarm slots held in a ring of cells, started, cancelled
// and counted down by command items, one result item per reported event.
// ----------------------------------------------------------------------------
// Items arrive on the in_ channel (command, duration, target id) and results
// leave on the out_ channel; both use valid and stall, and an item moves at
// an edge where valid is high and stall is low. out_last marks the final
// result of an input item. A tick with no busy slot, or an unknown command,
// gives no result at all.
// An item is taken only while the block is idle. It then rotates the slot
// ring once round, one slot a cycle through the head cell while the output
// register is free, and then issues its closing result in a done state.
// Each result is held back until the next one is found, and then appears in
// the cycle after the head cell has seen the slot that causes that next one;
// the last one is loaded into the output register from the done state after
// the rotation ends.
// While the receiver stalls a full output register, the rotation halts and
// resumes where it left off, so no result is lost or repeated.
// Reset frees every slot, clears the id counter and empties the output.
// ----------------------------------------------------------------------------
module multi_slot_alarm_timer #(
  parameter int SLOTS = mat_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_duration,
  input  logic [15:0] in_target_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_res,
  output logic [15:0] out_alarm_id,
  output logic [15:0] out_alarm_duration,
  output logic        out_last
);

  logic           shift;
  mat_pkg::slot_t head_upd;
  mat_pkg::slot_t cell_q [SLOTS];

  mat_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_duration        (in_duration),
    .in_target_id       (in_target_id),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_event_res      (out_event_res),
    .out_alarm_id       (out_alarm_id),
    .out_alarm_duration (out_alarm_duration),
    .out_last           (out_last),
    .shift              (shift),
    .head               (cell_q[0]),
    .head_upd           (head_upd)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    mat_pkg::slot_t cell_in;
    if (i == SLOTS - 1) begin : g_tail
      assign cell_in = head_upd;
    end else begin : g_mid
      assign cell_in = cell_q[i+1];
    end
    mat_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .slot_in  (cell_in),
      .slot_out (cell_q[i])
    );
  end

endmodule

/* design/mat_cell.sv */
// ----------------------------------------------------------------------------
// Alarm slot cell
// Holds one alarm slot and takes its neighbour's slot when the ring shifts.
// ----------------------------------------------------------------------------
module mat_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          shift,
  input  mat_pkg::slot_t slot_in,
  output mat_pkg::slot_t slot_out
);

  mat_pkg::slot_t slot_r;
  mat_pkg::slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (shift) begin
      slot_nxt = slot_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r.busy   <= 1'b0;
      slot_r.cancel <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_out = slot_r;

endmodule

/* design/mat_ctrl.sv */
// ----------------------------------------------------------------------------
// Alarm timer controller
// Accepts an item, rotates the slot ring once round while working on the
// slot at its head, and delivers the results through an output register.
// ----------------------------------------------------------------------------
module mat_ctrl #(
  parameter int SLOTS = mat_pkg::SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic [1:0]     in_command,
  input  logic [15:0]    in_duration,
  input  logic [15:0]    in_target_id,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [2:0]     out_event_res,
  output logic [15:0]    out_alarm_id,
  output logic [15:0]    out_alarm_duration,
  output logic           out_last,
  output logic           shift,
  input  mat_pkg::slot_t head,
  output mat_pkg::slot_t head_upd
);

  localparam int CntW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]      state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [1:0]      cmd_r, cmd_nxt;
  logic [15:0]     dur_r, dur_nxt;
  logic [15:0]     tgt_r, tgt_nxt;
  logic            found_r, found_nxt;
  logic [15:0]     next_id_r, next_id_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  mat_pkg::res_t   pend_r, pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  mat_pkg::res_t   out_r, out_nxt;
  logic            out_last_r, out_last_nxt;

  logic            out_free;
  logic            emit;
  mat_pkg::res_t   res;
  logic [15:0]     id_new;

  assign out_free = !out_valid_r || !out_stall;
  assign id_new   = next_id_r + 16'd1;

  always_comb begin
    head_upd = head;
    emit     = 1'b0;
    res      = '0;
    case (cmd_r)
      mat_pkg::CMD_START: begin
        if (!found_r && !head.busy) begin
          head_upd.busy      = 1'b1;
          head_upd.cancel    = 1'b0;
          head_upd.ident     = id_new;
          head_upd.remaining = dur_r;
          head_upd.length    = dur_r;
          emit               = 1'b1;
          res                = '{ev: mat_pkg::EV_STARTED, id: id_new, len: dur_r};
        end
      end
      mat_pkg::CMD_END: begin
        if (tgt_r != 16'd0 && head.busy && head.ident == tgt_r) begin
          head_upd.cancel = 1'b1;
          emit            = 1'b1;
          res = '{ev: mat_pkg::EV_SCHEDULED, id: head.ident, len: head.length};
        end
      end
      mat_pkg::CMD_TICK: begin
        if (head.busy) begin
          if (head.cancel) begin
            head_upd.busy   = 1'b0;
            head_upd.cancel = 1'b0;
            emit            = 1'b1;
            res = '{ev: mat_pkg::EV_ENDED, id: head.ident, len: head.length};
          end else if (head.remaining <= 16'd1) begin
            head_upd.busy   = 1'b0;
            head_upd.cancel = 1'b0;
            emit            = 1'b1;
            res = '{ev: mat_pkg::EV_RANG, id: head.ident, len: head.length};
          end else begin
            head_upd.remaining = head.remaining - 16'd1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    cmd_nxt        = cmd_r;
    dur_nxt        = dur_r;
    tgt_nxt        = tgt_r;
    found_nxt      = found_r;
    next_id_nxt    = next_id_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    out_valid_nxt  = out_valid_r && out_stall;
    shift          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_command inside {mat_pkg::CMD_START, mat_pkg::CMD_END,
                                 mat_pkg::CMD_TICK}) begin
            state_nxt      = ST_SCAN;
            cnt_nxt        = '0;
            cmd_nxt        = in_command;
            dur_nxt        = in_duration;
            tgt_nxt        = in_target_id;
            found_nxt      = 1'b0;
            pend_valid_nxt = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (out_free) begin
          shift = 1'b1;
          if (emit) begin
            found_nxt      = 1'b1;
            pend_valid_nxt = 1'b1;
            pend_nxt       = res;
            if (cmd_r == mat_pkg::CMD_START) begin
              next_id_nxt = id_new;
            end
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = pend_r;
              out_last_nxt  = 1'b0;
            end
          end
          if (cnt_r == CntW'(SLOTS - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            cnt_nxt = cnt_r + CntW'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt      = ST_IDLE;
          pend_valid_nxt = 1'b0;
          out_last_nxt   = 1'b1;
          if (pend_valid_r) begin
            out_valid_nxt = 1'b1;
            out_nxt       = pend_r;
          end else if (cmd_r == mat_pkg::CMD_START) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{ev: mat_pkg::EV_FULL, id: 16'd0, len: 16'd0};
          end else if (cmd_r == mat_pkg::CMD_END) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '{ev: mat_pkg::EV_NOT_FOUND, id: tgt_r, len: 16'd0};
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      found_r      <= 1'b0;
      next_id_r    <= 16'd0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      found_r      <= found_nxt;
      next_id_r    <= next_id_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    dur_r      <= dur_nxt;
    tgt_r      <= tgt_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_event_res      = out_r.ev;
  assign out_alarm_id       = out_r.id;
  assign out_alarm_duration = out_r.len;
  assign out_last           = out_last_r;

endmodule
